// ===== src/tgad_pkg.sv =====
// Shared types and constants for the TGA image stream decoder.
// Used by the channel interfaces and by the decoder core; no dependencies.
package tgad_pkg;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SKIP,
		PH_PACKET,
		PH_PIXEL,
		PH_DONE,
		PH_FAIL
	} phase_t;

	// Result kinds.
	typedef enum logic [2:0] {
		KIND_HEADER    = 3'd0,
		KIND_RUN       = 3'd1,
		KIND_BAD_TYPE  = 3'd2,
		KIND_BAD_DEPTH = 3'd3,
		KIND_TRUNC     = 3'd4
	} kind_t;

	// Header byte positions that carry fields.
	localparam logic [4:0] HB_ID_LEN   = 5'd0;
	localparam logic [4:0] HB_TYPE     = 5'd2;
	localparam logic [4:0] HB_MAP_LO   = 5'd5;
	localparam logic [4:0] HB_MAP_HI   = 5'd6;
	localparam logic [4:0] HB_WIDTH_LO = 5'd12;
	localparam logic [4:0] HB_WIDTH_HI = 5'd13;
	localparam logic [4:0] HB_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HB_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HB_DEPTH    = 5'd16;
	localparam logic [4:0] HB_LAST     = 5'd17;

	localparam logic [7:0] TYPE_RAW = 8'd2;
	localparam logic [7:0] TYPE_RLE = 8'd10;
	localparam logic [7:0] BPP_24   = 8'd24;
	localparam logic [7:0] BPP_32   = 8'd32;
	localparam logic [5:0] DEPTH_24 = 6'd24;
	localparam logic [5:0] DEPTH_32 = 6'd32;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
		logic       file_end;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [5:0]  pixel_depth;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  run_length;
		logic        image_done;
	} out_item_t;

endpackage

// ===== src/tgad_in_if.sv =====
// Valid/ready channel that carries file bytes into the decoder.
// Depends on tgad_pkg for the beat payload type.
interface tgad_in_if;
	import tgad_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/tgad_out_if.sv =====
// Valid/ready channel that carries decoder results.
// Depends on tgad_pkg for the beat payload type.
interface tgad_out_if;
	import tgad_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/tga_image_stream_decoder_core.sv =====
// TGA true-color stream decoder core: header parser, skip counter, RLE unpacker.
// Depends on tgad_pkg and the tgad_in_if / tgad_out_if channel interfaces.
//
// Usage:
//   byte_stream takes one file byte per beat, with file_start on byte 0 of a
//   file and file_end on the last byte available. result_stream gives at most
//   one result per input beat: a header record after header byte 17, a pixel
//   run per decoded pixel or repeat packet, or an error (bad type, bad depth,
//   truncated file). Bytes that cause no result are consumed silently.
//   Timing: a byte is registered in the input register at acceptance, and its
//   result is loaded into the output register, which drives result_stream valid,
//   when the processing stage advances. Throughput is one byte per cycle while
//   the output register is not held by a stalled receiver; every byte is
//   handled by a single pass of logic in the processing stage.
//   Reset clears the parser to idle; bytes are ignored until one arrives with
//   file_start. When the receiver stalls, the result waits in the output
//   register and one more byte is held in the input register; byte_stream
//   ready drops only while both are occupied.
module tga_image_stream_decoder_core (
	input  logic              clk,
	input  logic              arst_n,
	tgad_in_if.sink           byte_stream,
	tgad_out_if.source        result_stream
);
	import tgad_pkg::*;

	// Input stage.
	logic      valid_s1;
	in_item_t  item_s1;

	// Parser state.
	phase_t      phase_q;
	logic [4:0]  hidx_q;
	logic [7:0]  id_q;
	logic        rle_q;
	logic [15:0] map_q;
	logic [19:0] skip_q;
	logic [15:0] w_q;
	logic [15:0] h_q;
	logic        alpha_q;
	logic [31:0] pix_q;
	logic [7:0]  phdr_q;
	logic [7:0]  raw_q;
	logic [1:0]  bip_q;
	logic [7:0]  b0_q;
	logic [7:0]  b1_q;
	logic [7:0]  b2_q;

	// Output register.
	logic      out_valid_q;
	out_item_t out_q;

	// Next-state values.
	phase_t      n_phase;
	logic [4:0]  n_hidx;
	logic [7:0]  n_id;
	logic        n_rle;
	logic [15:0] n_map;
	logic [19:0] n_skip;
	logic [15:0] n_w;
	logic [15:0] n_h;
	logic        n_alpha;
	logic [31:0] n_pix;
	logic [7:0]  n_phdr;
	logic [7:0]  n_raw;
	logic [1:0]  n_bip;
	logic [7:0]  n_b0;
	logic [7:0]  n_b1;
	logic [7:0]  n_b2;
	logic        have;
	out_item_t   res;

	logic        proc;
	logic [19:0] skip_sum;
	logic [17:0] map_bytes;
	logic [31:0] area;
	logic        area_zero;

	// The processing stage advances when it holds a byte and the output register can take a result.
	assign proc = valid_s1 && (!out_valid_q || result_stream.ready);
	assign byte_stream.ready = !valid_s1 || proc;

	assign result_stream.valid = out_valid_q;
	assign result_stream.data  = out_q;

	// Header-end arithmetic uses the fields registered on earlier bytes.
	assign map_bytes = alpha_q ? {map_q, 2'b00}
		: ({2'b00, map_q} + {1'b0, map_q, 1'b0});
	assign skip_sum  = {12'd0, id_q} + {2'b00, map_bytes};
	assign area      = w_q * h_q;
	assign area_zero = (w_q == 16'd0) || (h_q == 16'd0);

	always_comb begin
		logic [7:0] b;
		logic [1:0] bip_cur;
		logic       last;
		logic       rep;
		logic [7:0] run8;
		logic [7:0] clip;
		logic       done;

		b       = item_s1.data_byte;
		n_phase = phase_q;
		n_hidx  = hidx_q;
		n_id    = id_q;
		n_rle   = rle_q;
		n_map   = map_q;
		n_skip  = skip_q;
		n_w     = w_q;
		n_h     = h_q;
		n_alpha = alpha_q;
		n_pix   = pix_q;
		n_phdr  = phdr_q;
		n_raw   = raw_q;
		n_bip   = bip_q;
		n_b0    = b0_q;
		n_b1    = b1_q;
		n_b2    = b2_q;
		have    = 1'b0;
		res     = '0;
		bip_cur = 2'd0;
		last    = 1'b0;
		rep     = 1'b0;
		run8    = 8'd0;
		clip    = 8'd0;
		done    = 1'b0;

		if (item_s1.file_start) begin
			n_phase = PH_HEADER;
			n_hidx  = '0;
			n_id    = '0;
			n_rle   = 1'b0;
			n_map   = '0;
			n_skip  = '0;
			n_w     = '0;
			n_h     = '0;
			n_alpha = 1'b0;
			n_pix   = '0;
			n_phdr  = '0;
			n_raw   = '0;
			n_bip   = '0;
		end

		unique case (n_phase)
			PH_HEADER: begin
				unique case (n_hidx)
					HB_ID_LEN: n_id = b;
					HB_TYPE: begin
						if (b == TYPE_RAW || b == TYPE_RLE) begin
							n_rle = (b == TYPE_RLE);
						end else begin
							n_phase  = PH_FAIL;
							res.kind = KIND_BAD_TYPE;
							have     = 1'b1;
						end
					end
					HB_MAP_LO:    n_map[7:0]  = b;
					HB_MAP_HI:    n_map[15:8] = b;
					HB_WIDTH_LO:  n_w[7:0]    = b;
					HB_WIDTH_HI:  n_w[15:8]   = b;
					HB_HEIGHT_LO: n_h[7:0]    = b;
					HB_HEIGHT_HI: n_h[15:8]   = b;
					HB_DEPTH: begin
						if (b == BPP_24 || b == BPP_32) begin
							n_alpha = (b == BPP_32);
						end else begin
							n_phase  = PH_FAIL;
							res.kind = KIND_BAD_DEPTH;
							have     = 1'b1;
						end
					end
					HB_LAST: begin
						n_skip = skip_sum;
						n_pix  = area;
						if (area_zero) begin
							n_phase = PH_DONE;
						end else if (skip_sum != 20'd0) begin
							n_phase = PH_SKIP;
						end else begin
							n_phase = n_rle ? PH_PACKET : PH_PIXEL;
							n_bip   = '0;
						end
						res.kind         = KIND_HEADER;
						res.image_width  = w_q;
						res.image_height = h_q;
						res.pixel_depth  = alpha_q ? DEPTH_32 : DEPTH_24;
						have             = 1'b1;
					end
					default: ;
				endcase
				if (n_phase == PH_HEADER) begin
					n_hidx = n_hidx + 5'd1;
				end
			end
			PH_SKIP: begin
				if (n_skip == 20'd1) begin
					n_phase = n_rle ? PH_PACKET : PH_PIXEL;
					n_bip   = '0;
				end
				n_skip = n_skip - 20'd1;
			end
			PH_PACKET: begin
				n_phdr  = b;
				n_raw   = {1'b0, b[6:0]} + 8'd1;
				n_phase = PH_PIXEL;
				n_bip   = '0;
			end
			PH_PIXEL: begin
				bip_cur = n_bip;
				unique case (bip_cur)
					2'd0: n_b0 = b;
					2'd1: n_b1 = b;
					2'd2: n_b2 = b;
					default: ;
				endcase
				last  = (bip_cur == 2'd3) || (bip_cur == 2'd2 && !n_alpha);
				n_bip = bip_cur + 2'd1;
				if (last) begin
					rep  = n_rle && n_phdr[7];
					run8 = rep ? ({1'b0, n_phdr[6:0]} + 8'd1) : 8'd1;
					clip = (n_pix < {24'd0, run8}) ? n_pix[7:0] : run8;
					done = (n_pix <= {24'd0, run8});
					n_pix = n_pix - {24'd0, clip};

					res.kind       = KIND_RUN;
					res.blue       = b0_q;
					res.green      = b1_q;
					res.red        = (bip_cur == 2'd3) ? b2_q : b;
					res.alpha      = (bip_cur == 2'd3) ? b : 8'd0;
					res.run_length = clip;
					res.image_done = done;
					have           = 1'b1;
					n_bip          = '0;

					if (done) begin
						n_phase = PH_DONE;
					end else if (n_rle) begin
						if (rep || n_raw == 8'd1) begin
							n_phase = PH_PACKET;
						end
						if (!rep) begin
							n_raw = n_raw - 8'd1;
						end
					end
				end
			end
			default: ;
		endcase

		// A file that ends before the image is complete overrides any other result.
		if (item_s1.file_end && n_phase != PH_IDLE && n_phase != PH_DONE
			&& n_phase != PH_FAIL) begin
			res      = '0;
			res.kind = KIND_TRUNC;
			have     = 1'b1;
			n_phase  = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			item_s1 <= byte_stream.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hidx_q  <= '0;
			id_q    <= '0;
			rle_q   <= 1'b0;
			map_q   <= '0;
			skip_q  <= '0;
			w_q     <= '0;
			h_q     <= '0;
			alpha_q <= 1'b0;
			pix_q   <= '0;
			phdr_q  <= '0;
			raw_q   <= '0;
			bip_q   <= '0;
		end else if (proc) begin
			phase_q <= n_phase;
			hidx_q  <= n_hidx;
			id_q    <= n_id;
			rle_q   <= n_rle;
			map_q   <= n_map;
			skip_q  <= n_skip;
			w_q     <= n_w;
			h_q     <= n_h;
			alpha_q <= n_alpha;
			pix_q   <= n_pix;
			phdr_q  <= n_phdr;
			raw_q   <= n_raw;
			bip_q   <= n_bip;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			b0_q <= n_b0;
			b1_q <= n_b1;
			b2_q <= n_b2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= have;
		end else if (result_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && have) begin
			out_q <= res;
		end
	end

	// The input side stalls only when both the input stage and a blocked result are held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_stream.ready |-> (valid_s1 && out_valid_q && !result_stream.ready))
		else $error("byte_stream stalled without a blocked result");

	a_pixels_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXEL || phase_q == PH_PACKET || phase_q == PH_SKIP)
		|-> (pix_q != 32'd0))
		else $error("pixel decoding active with no pixels left");

	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.image_done) |-> (out_q.kind == KIND_RUN))
		else $error("image_done set on a result that is not a pixel run");

	a_bip_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXEL && !alpha_q) |-> (bip_q != 2'd3))
		else $error("fourth pixel byte expected in a 24-bit image");

	a_header_index: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |-> (hidx_q <= HB_LAST))
		else $error("header index ran past the last header byte");

	a_result_after_proc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(proc))
		else $error("result appeared without a processed byte");

endmodule

// ===== tb/tb_tga_image_stream_decoder_core.sv =====
// Self-checking testbench for the TGA true-color stream decoder core.
// Needs tgad_pkg, tgad_in_if, tgad_out_if and tga_image_stream_decoder_core.
// Whole and broken image files go in byte by byte; each result is checked on the fly.
`timescale 1ns / 100ps

module tb_tga_image_stream_decoder_core;
	import tgad_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned FILE_BYTE_TARGET = 700;
	localparam int unsigned DRAIN_LIMIT = 2000;
	localparam logic [7:0] REPEAT_FLAG = 8'h80;

	typedef enum int {
		FK_RLE,
		FK_RAW,
		FK_CUT,
		FK_ABANDON,
		FK_BAD_TYPE,
		FK_BAD_DEPTH,
		FK_HUGE,
		FK_EMPTY,
		FK_NOISE
	} file_kind_t;

	// Tracks the decoder's parse state and holds the results still to come.
	class tga_decode_board;
		out_item_t   pending_results[$];
		int unsigned fail_cnt;

		phase_t      phase;
		logic [4:0]  hdr_idx;
		logic [7:0]  id_len;
		bit          rle;
		logic [15:0] map_len;
		logic [19:0] skip_left;
		logic [15:0] img_w;
		logic [15:0] img_h;
		bit          has_a;
		logic [31:0] px_left;
		logic [7:0]  pkt_hdr;
		logic [7:0]  raw_left;
		logic [31:0] px_word;
		logic [1:0]  byte_idx;

		function new();
			fail_cnt = 0;
			clear_state();
		endfunction

		function void clear_state();
			phase = PH_IDLE;
			hdr_idx = '0;
			id_len = '0;
			rle = 1'b0;
			map_len = '0;
			skip_left = '0;
			img_w = '0;
			img_h = '0;
			has_a = 1'b0;
			px_left = '0;
			pkt_hdr = '0;
			raw_left = '0;
			px_word = '0;
			byte_idx = '0;
		endfunction

		function void enter_pixels();
			phase = rle ? PH_PACKET : PH_PIXEL;
			byte_idx = '0;
			px_word = '0;
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction

		function void note_byte(in_item_t it);
			out_item_t   res;
			bit          have;
			logic [7:0]  b;
			logic [31:0] run;
			logic [31:0] skip_full;
			logic [2:0]  bpp;
			bit          rpt;

			res = '0;
			have = 1'b0;
			b = it.data_byte;
			if (it.file_start) begin
				clear_state();
				phase = PH_HEADER;
			end
			case (phase)
				PH_HEADER: begin
					case (hdr_idx)
						HB_ID_LEN: id_len = b;
						HB_TYPE: begin
							if (b == TYPE_RAW || b == TYPE_RLE) begin
								rle = (b == TYPE_RLE);
							end else begin
								phase = PH_FAIL;
								res.kind = KIND_BAD_TYPE;
								have = 1'b1;
							end
						end
						HB_MAP_LO: map_len[7:0] = b;
						HB_MAP_HI: map_len[15:8] = b;
						HB_WIDTH_LO: img_w[7:0] = b;
						HB_WIDTH_HI: img_w[15:8] = b;
						HB_HEIGHT_LO: img_h[7:0] = b;
						HB_HEIGHT_HI: img_h[15:8] = b;
						HB_DEPTH: begin
							if (b == BPP_24 || b == BPP_32) begin
								has_a = (b == BPP_32);
							end else begin
								phase = PH_FAIL;
								res.kind = KIND_BAD_DEPTH;
								have = 1'b1;
							end
						end
						HB_LAST: begin
							skip_full = 32'(id_len) + 32'(map_len) * (has_a ? 32'd4 : 32'd3);
							skip_left = skip_full[19:0];
							px_left = 32'(img_w) * 32'(img_h);
							if (px_left == 0)
								phase = PH_DONE;
							else if (skip_left != 0)
								phase = PH_SKIP;
							else
								enter_pixels();
							res.kind = KIND_HEADER;
							res.image_width = img_w;
							res.image_height = img_h;
							res.pixel_depth = has_a ? DEPTH_32 : DEPTH_24;
							have = 1'b1;
						end
						default: ;
					endcase
					if (phase == PH_HEADER)
						hdr_idx = hdr_idx + 5'd1;
				end
				PH_SKIP: begin
					skip_left = skip_left - 20'd1;
					if (skip_left == 0)
						enter_pixels();
				end
				PH_PACKET: begin
					pkt_hdr = b;
					raw_left = {1'b0, b[6:0]} + 8'd1;
					phase = PH_PIXEL;
					byte_idx = '0;
					px_word = '0;
				end
				PH_PIXEL: begin
					bpp = has_a ? 3'd4 : 3'd3;
					px_word = px_word | (32'(b) << (8 * byte_idx));
					byte_idx = byte_idx + 2'd1;
					// A 32-bit pixel completes when the byte counter wraps to zero.
					if (byte_idx >= bpp || byte_idx == 0) begin
						rpt = rle && pkt_hdr[7];
						run = rpt ? 32'(pkt_hdr[6:0]) + 32'd1 : 32'd1;
						if (run > px_left)
							run = px_left;
						px_left = px_left - run;
						res.kind = KIND_RUN;
						res.red = px_word[23:16];
						res.green = px_word[15:8];
						res.blue = px_word[7:0];
						res.alpha = has_a ? px_word[31:24] : 8'd0;
						res.run_length = run[7:0];
						res.image_done = (px_left == 0);
						have = 1'b1;
						byte_idx = '0;
						px_word = '0;
						if (px_left == 0) begin
							phase = PH_DONE;
						end else if (rle) begin
							if (rpt) begin
								phase = PH_PACKET;
							end else begin
								raw_left = raw_left - 8'd1;
								if (raw_left == 0)
									phase = PH_PACKET;
							end
						end
					end
				end
				default: ;
			endcase
			// A file that stops before the image is complete overrides any other result.
			if (it.file_end && phase != PH_IDLE && phase != PH_DONE && phase != PH_FAIL) begin
				res = '0;
				res.kind = KIND_TRUNC;
				have = 1'b1;
				phase = PH_IDLE;
			end
			if (have)
				pending_results.push_back(res);
		endfunction

		function string show(out_item_t r);
			return $sformatf("kind=%0d w=%0d h=%0d depth=%0d rgba=%02h %02h %02h %02h run=%0d done=%0b",
				r.kind, r.image_width, r.image_height, r.pixel_depth,
				r.red, r.green, r.blue, r.alpha, r.run_length, r.image_done);
		endfunction

		function void note_failure(string msg);
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("%s", msg);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			bit        bad;

			if (pending_results.size() == 0) begin
				note_failure({"unexpected result: ", show(got)});
				return;
			end
			want = pending_results.pop_front();
			bad = (got.kind !== want.kind) ||
				(got.image_width !== want.image_width) ||
				(got.image_height !== want.image_height) ||
				(got.pixel_depth !== want.pixel_depth) ||
				(got.red !== want.red) ||
				(got.green !== want.green) ||
				(got.blue !== want.blue) ||
				(got.alpha !== want.alpha) ||
				(got.run_length !== want.run_length) ||
				(got.image_done !== want.image_done);
			if (bad)
				note_failure({"result mismatch: expected ", show(want), " got ", show(got)});
		endfunction

		function void report_leftover();
			while (pending_results.size() != 0)
				note_failure({"missing result: ", show(pending_results.pop_front())});
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tgad_in_if  byte_ch();
	tgad_out_if result_ch();

	tga_decode_board board = new();

	logic [7:0]  file_buf[$];
	int unsigned file_bytes = 0;
	int unsigned rx_hold = 0;
	int unsigned cycle_cnt = 0;

	tga_image_stream_decoder_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_stream   (byte_ch),
		.result_stream (result_ch)
	);

	always #1 clk = ~clk;

	// Offers one byte, after a random gap unless in burst mode, and waits for the beat to be taken.
	task automatic send_byte(input in_item_t it, input bit burst);
		int unsigned gap;

		gap = burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data <= it;
		do @(posedge clk); while (!byte_ch.ready);
		board.note_byte(it);
	endtask

	task automatic send_file(input int unsigned n_send, input bit end_flag, input bit burst);
		in_item_t it;

		for (int unsigned i = 0; i < n_send; i++) begin
			it.data_byte = file_buf[i];
			it.file_start = (i == 0);
			it.file_end = end_flag && (i == n_send - 1);
			send_byte(it, burst);
			file_bytes++;
		end
		file_buf.delete();
	endtask

	// The sender stops offering bytes until every expected result has come out.
	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void push_pixel(input bit a);
		repeat (a ? 4 : 3) file_buf.push_back(rand_byte());
	endfunction

	function automatic void push_header(input logic [7:0] idl, input logic [7:0] typ,
			input logic [15:0] ml, input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] dep);
		for (int i = 0; i <= HB_LAST; i++) begin
			case (5'(i))
				HB_ID_LEN: file_buf.push_back(idl);
				HB_TYPE: file_buf.push_back(typ);
				HB_MAP_LO: file_buf.push_back(ml[7:0]);
				HB_MAP_HI: file_buf.push_back(ml[15:8]);
				HB_WIDTH_LO: file_buf.push_back(w[7:0]);
				HB_WIDTH_HI: file_buf.push_back(w[15:8]);
				HB_HEIGHT_LO: file_buf.push_back(h[7:0]);
				HB_HEIGHT_HI: file_buf.push_back(h[15:8]);
				HB_DEPTH: file_buf.push_back(dep);
				default: file_buf.push_back(rand_byte());
			endcase
		end
	endfunction

	// Builds a well-formed file; run-coded bodies mix repeat and raw packets.
	function automatic void build_image(input bit rle, input bit a, input int unsigned w,
			input int unsigned h, input int unsigned idl, input int unsigned ml);
		int unsigned total;
		int unsigned covered;
		int unsigned cnt;

		push_header(8'(idl), rle ? TYPE_RLE : TYPE_RAW, 16'(ml), 16'(w), 16'(h),
			a ? BPP_32 : BPP_24);
		repeat (idl + ml * (a ? 4 : 3)) file_buf.push_back(rand_byte());
		total = w * h;
		covered = 0;
		if (!rle) begin
			repeat (total) push_pixel(a);
		end else begin
			while (covered < total) begin
				if ($urandom_range(0, 1) == 1) begin
					cnt = ($urandom_range(0, 3) == 0) ? 128 : $urandom_range(1, 128);
					file_buf.push_back(REPEAT_FLAG | 8'(cnt - 1));
					push_pixel(a);
				end else begin
					cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128)
						: $urandom_range(1, 6);
					file_buf.push_back(8'(cnt - 1));
					repeat (cnt) push_pixel(a);
				end
				covered += cnt;
			end
		end
	endfunction

	function automatic void build_small_image();
		build_image(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom_range(1, 6),
			$urandom_range(1, 4), $urandom_range(0, 3), $urandom_range(0, 2));
	endfunction

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tga_image_stream_decoder_core regression: fail");
		$finish;
	end

	initial begin : result_sink
		int unsigned stall_left;
		int unsigned rx_cnt;

		stall_left = 0;
		rx_cnt = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				board.check_result(result_ch.data);
				rx_cnt++;
				stall_left = (rx_cnt % 48 < 16) ? 0 : $urandom_range(0, 15);
			end
			// A long hold lets the core fill up and push back on its input.
			if (rx_hold != 0) begin
				stall_left = rx_hold;
				rx_hold = 0;
			end
			if (stall_left != 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : byte_source
		in_item_t    it;
		file_kind_t  fk;
		int unsigned file_no;
		int unsigned guard;
		bit          burst;
		bit          hold;
		logic [7:0]  bad_code;

		byte_ch.valid <= 1'b0;
		byte_ch.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes while idle are dropped, even one flagged as the file's end.
		it = '{data_byte: 8'hff, file_start: 1'b0, file_end: 1'b0};
		send_byte(it, 1'b0);
		it = '{data_byte: 8'h00, file_start: 1'b0, file_end: 1'b1};
		send_byte(it, 1'b0);
		// A file that starts and ends on the same byte is truncated.
		it = '{data_byte: 8'h5a, file_start: 1'b1, file_end: 1'b1};
		send_byte(it, 1'b0);
		file_buf = '{8'h00, 8'h00, 8'hff};
		send_file(3, 1'b0, 1'b1);
		// Widest image with no rows: header only, nothing follows.
		push_header(8'h00, TYPE_RLE, 16'h0000, 16'hffff, 16'h0000, BPP_32);
		send_file(file_buf.size(), 1'b1, 1'b0);

		file_no = 0;
		while (file_bytes < FILE_BYTE_TARGET) begin
			file_no++;
			burst = ($urandom_range(0, 3) == 0);
			hold = (file_no % 9 == 4);
			if (file_no % 6 == 0)
				wait_drained();
			if (hold) begin
				fk = file_kind_t'($urandom_range(FK_RLE, FK_RAW));
				burst = 1'b1;
				rx_hold = $urandom_range(100, 300);
			end else if (file_no <= 9) begin
				fk = file_kind_t'(file_no - 1);
			end else if ($urandom_range(0, 1) == 1) begin
				fk = file_kind_t'($urandom_range(FK_RLE, FK_RAW));
			end else begin
				fk = file_kind_t'($urandom_range(FK_RLE, FK_NOISE));
			end
			file_buf.delete();
			case (fk)
				FK_RLE, FK_RAW: begin
					if (fk == FK_RLE && $urandom_range(0, 3) == 0)
						build_image(1'b1, 1'($urandom_range(0, 1)), $urandom_range(20, 150),
							$urandom_range(1, 3), 0, 0);
					else
						build_image(fk == FK_RLE, 1'($urandom_range(0, 1)),
							$urandom_range(1, 10), $urandom_range(1, 5),
							($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0,
							($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
					repeat ($urandom_range(0, 3)) file_buf.push_back(rand_byte());
					send_file(file_buf.size(), 1'($urandom_range(0, 1)), burst);
				end
				FK_CUT: begin
					build_small_image();
					send_file($urandom_range(1, file_buf.size()), 1'b1, burst);
				end
				FK_ABANDON: begin
					// The next file's start byte cuts this one off.
					build_small_image();
					send_file($urandom_range(1, file_buf.size()), 1'b0, burst);
				end
				FK_BAD_TYPE: begin
					do bad_code = rand_byte(); while (bad_code == TYPE_RAW || bad_code == TYPE_RLE);
					push_header(rand_byte(), bad_code, 16'($urandom), 16'($urandom),
						16'($urandom), BPP_24);
					repeat ($urandom_range(0, 4)) file_buf.push_back(rand_byte());
					send_file($urandom_range(3, file_buf.size()), 1'($urandom_range(0, 1)),
						burst);
				end
				FK_BAD_DEPTH: begin
					do bad_code = rand_byte(); while (bad_code == BPP_24 || bad_code == BPP_32);
					push_header(8'($urandom_range(0, 3)), $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW,
						16'($urandom), 16'($urandom), 16'($urandom), bad_code);
					repeat ($urandom_range(0, 4)) file_buf.push_back(rand_byte());
					send_file(file_buf.size(), 1'($urandom_range(0, 1)), burst);
				end
				FK_HUGE: begin
					// Usually far too large to send whole; the end flag arrives early.
					push_header(rand_byte(), $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW,
						($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'h0000,
						16'($urandom), 16'($urandom), $urandom_range(0, 1) ? BPP_32 : BPP_24);
					repeat ($urandom_range(0, 20)) file_buf.push_back(rand_byte());
					send_file(file_buf.size(), 1'b1, burst);
				end
				FK_EMPTY: begin
					if ($urandom_range(0, 1) == 1)
						push_header(rand_byte(), TYPE_RAW, 16'($urandom), 16'h0000,
							16'($urandom), BPP_24);
					else
						push_header(rand_byte(), TYPE_RLE, 16'($urandom), 16'($urandom),
							16'h0000, BPP_32);
					repeat ($urandom_range(0, 4)) file_buf.push_back(rand_byte());
					send_file(file_buf.size(), 1'($urandom_range(0, 1)), burst);
				end
				default: begin
					repeat ($urandom_range(3, 10)) begin
						it.data_byte = rand_byte();
						it.file_start = ($urandom_range(0, 7) == 0);
						it.file_end = 1'($urandom_range(0, 1));
						send_byte(it, burst);
					end
				end
			endcase
		end

		byte_ch.valid <= 1'b0;
		guard = 0;
		while (guard < DRAIN_LIMIT && board.pending() != 0) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		board.report_leftover();
		if (board.fail_cnt == 0)
			$display("tga_image_stream_decoder_core regression: pass");
		else
			$display("tga_image_stream_decoder_core regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
src/tgad_pkg.sv
src/tgad_in_if.sv
src/tgad_out_if.sv
src/tga_image_stream_decoder_core.sv
tb/tb_tga_image_stream_decoder_core.sv
